>>> rtl/fsts_pkg.sv
// shared widths, fibonacci constants and state codes of the fibonacci search table
`timescale 1ns / 1ps
`default_nettype none

package fsts_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 256;

  localparam int unsigned IDX_W = 9;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CNT_W = 4;
  localparam int unsigned POS_W = 12;
  localparam int unsigned FIB_N = 16;
  localparam int unsigned FIB_K_W = 4;

  localparam int unsigned IN_TDATA_W = 80;
  localparam int unsigned OUT_TDATA_W = 16;

  localparam int unsigned IN_IDX_LSB = 0;
  localparam int unsigned IN_VAL_LSB = IN_IDX_LSB + IDX_W;
  localparam int unsigned IN_KEY_LSB = IN_VAL_LSB + VAL_W;
  localparam int unsigned IN_USED_W = IN_KEY_LSB + VAL_W;

  localparam int unsigned OUT_POS_LSB = 0;
  localparam int unsigned OUT_CNT_LSB = OUT_POS_LSB + IDX_W;
  localparam int unsigned OUT_USED_W = OUT_CNT_LSB + CNT_W;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [POS_W-1:0] FIB_TABLE [FIB_N] = '{
    12'd0, 12'd1, 12'd1, 12'd2, 12'd3, 12'd5, 12'd8, 12'd13,
    12'd21, 12'd34, 12'd55, 12'd89, 12'd144, 12'd233, 12'd377, 12'd610
  };

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SETUP = 5'b00010,
    ST_PROBE = 5'b00100,
    ST_CHECK = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

endpackage

`default_nettype wire

>>> rtl/fibonacci_search_table_unit.sv
// fibonacci search over a sorted signed table loaded one entry per word
//
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tuser: operation, tdata: index, value, key
//  m_axis    out  m_axis_tvalid/tready       tuser: found, tdata: position, probe count
//  cfg       in   cfg_valid/cfg_ready        cfg_data: entry_count
//
//  a load word leaves the block idle, so the next word is taken right after it
//  a search steps through setup, then a probe and a check for every probe, then done;
//  every probe is one registered read of the single table memory followed by one compare
//  a finished result sits in the output register while the next word is taken
//  reset clears control state only; table entries are undefined until loaded
`timescale 1ns / 1ps
`default_nettype none

module fibonacci_search_table_unit #(
  parameter int unsigned TABLE_DEPTH = fsts_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // entry_index, entry_value, search_key
  input  wire logic [fsts_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // operation
  input  wire logic                             s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // position, probe_count
  output logic [fsts_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  // found
  output logic                                  m_axis_tuser,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [fsts_pkg::IDX_W-1:0]       cfg_data
);

  import fsts_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  state_e state_q, state_d;

  logic [IDX_W-1:0]   entry_count_q;
  logic [VAL_W-1:0]   mem_q [TABLE_DEPTH];
  logic [VAL_W-1:0]   rd_q;

  logic [POS_W-1:0]   low_q, high_q, pc_q;
  logic [FIB_K_W-1:0] k_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               hit_q;
  logic [VAL_W-1:0]   key_q;

  logic               out_valid_q;
  logic               out_found_q;
  logic [IDX_W-1:0]   out_pos_q;
  logic [CNT_W-1:0]   out_cnt_q;

  logic               in_fire;
  logic [IDX_W-1:0]   in_idx;
  logic [VAL_W-1:0]   in_val;
  logic [VAL_W-1:0]   in_key;
  logic [IDX_W-1:0]   n;
  logic [POS_W-1:0]   n_ext;
  logic [FIB_K_W-1:0] k_init;
  logic [POS_W-1:0]   probe_pos;
  logic [POS_W-1:0]   probe_clamp;
  logic               loop_go;
  logic               out_free;
  logic               load_ok;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign in_idx  = s_axis_tdata[IN_IDX_LSB +: IDX_W];
  assign in_val  = s_axis_tdata[IN_VAL_LSB +: VAL_W];
  assign in_key  = s_axis_tdata[IN_KEY_LSB +: VAL_W];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_free      = !out_valid_q || m_axis_tready;

  // entries in use, limited to the table depth
  always_comb begin
    if (int'(entry_count_q) > int'(TABLE_DEPTH)) begin
      n = IDX_W'(TABLE_DEPTH);
    end else begin
      n = entry_count_q;
    end
  end
  assign n_ext = POS_W'(n);

  // smallest k with fib(k) >= n + 1
  always_comb begin
    k_init = FIB_K_W'(FIB_N - 1);
    for (int i = FIB_N - 1; i >= 0; i--) begin
      if (FIB_TABLE[i] >= n_ext + POS_W'(1)) begin
        k_init = FIB_K_W'(i);
      end
    end
  end

  assign loop_go     = (low_q <= high_q) && (k_q >= FIB_K_W'(3));
  assign probe_pos   = low_q + FIB_TABLE[k_q - FIB_K_W'(1)] - POS_W'(1);
  assign probe_clamp = (probe_pos > n_ext) ? n_ext : probe_pos;
  assign load_ok     = (in_idx != '0) && (int'(in_idx) <= int'(TABLE_DEPTH));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && s_axis_tuser == OP_SEARCH) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: state_d = ST_PROBE;
      ST_PROBE: begin
        state_d = loop_go ? ST_CHECK : ST_DONE;
      end
      ST_CHECK: begin
        state_d = ($signed(key_q) == $signed(rd_q)) ? ST_DONE : ST_PROBE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      entry_count_q <= '0;
      low_q         <= POS_W'(1);
      high_q        <= '0;
      k_q           <= '0;
      cnt_q         <= '0;
      hit_q         <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid && cfg_ready) begin
        entry_count_q <= cfg_data;
      end
      unique case (state_q)
        ST_SETUP: begin
          low_q  <= POS_W'(1);
          high_q <= n_ext;
          k_q    <= k_init;
          cnt_q  <= '0;
          hit_q  <= 1'b0;
        end
        ST_PROBE: begin
          if (loop_go && cnt_q != CNT_MAX) begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        ST_CHECK: begin
          if ($signed(key_q) < $signed(rd_q)) begin
            high_q <= pc_q - POS_W'(1);
            k_q    <= k_q - FIB_K_W'(1);
          end else if ($signed(key_q) > $signed(rd_q)) begin
            low_q <= pc_q + POS_W'(1);
            k_q   <= k_q - FIB_K_W'(2);
          end else begin
            hit_q <= 1'b1;
          end
        end
        default: ;
      endcase
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire && s_axis_tuser == OP_SEARCH) begin
      key_q <= in_key;
    end
    if (state_q == ST_PROBE) begin
      pc_q <= probe_pos;
    end
    if (state_q == ST_DONE && out_free) begin
      out_found_q <= hit_q;
      out_pos_q   <= hit_q ? IDX_W'(pc_q > n_ext ? n_ext : pc_q) : '0;
      out_cnt_q   <= cnt_q;
    end
  end

  // table memory, one write port and one registered read port
  always_ff @(posedge clk_i) begin
    if (in_fire && s_axis_tuser == OP_LOAD && load_ok) begin
      mem_q[AW'(in_idx - IDX_W'(1))] <= in_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_PROBE && loop_go) begin
      rd_q <= mem_q[AW'(probe_clamp - POS_W'(1))];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_found_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - OUT_USED_W)'(0), out_cnt_q, out_pos_q};

endmodule

`default_nettype wire

>>> rtl/fsts_checker.sv
// port level checks of the fibonacci search table, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module fsts_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             s_axis_tvalid,
  input wire logic                             s_axis_tready,
  input wire logic                             s_axis_tuser,
  input wire logic                             m_axis_tvalid,
  input wire logic                             m_axis_tready,
  input wire logic [fsts_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input wire logic                             m_axis_tuser
);

  import fsts_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // a miss reports position zero
  a_miss_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[OUT_POS_LSB +: IDX_W] == '0)
    else $error("miss with nonzero position");

  // a hit needs at least one probe and a real position
  a_hit_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[OUT_CNT_LSB +: CNT_W] != '0 && m_axis_tdata[OUT_POS_LSB +: IDX_W] != '0)
    else $error("hit without probe or position");

  // a search word occupies the block
  a_search_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_SEARCH |=> !s_axis_tready)
    else $error("ready right after a search word");

endmodule

bind fibonacci_search_table_unit fsts_checker u_fsts_checker (.*);

`default_nettype wire

>>> tb/tb_top.sv
// self-checking testbench of the fibonacci search table over its load, search and count ports
`timescale 1ns / 1ps

module tb_top;
  import fsts_pkg::*;

  localparam int unsigned DEPTH = 256;
  localparam int unsigned ITEM_GOAL = 1200;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned SETTLE_CYCLES = 60;
  localparam int unsigned FIB_LEN = 32;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] position;
    logic [CNT_W-1:0] probes;
  } search_result_t;

  class fib_search_checker;
    logic [VAL_W-1:0] entries [DEPTH];
    logic [IDX_W-1:0] entry_count;
    logic [IDX_W-1:0] last_low;
    logic [IDX_W-1:0] last_high;
    logic [3:0]       last_step;
    search_result_t   pending_results [$];
    int unsigned      mismatches;

    function new();
      foreach (entries[i]) entries[i] = '0;
      entry_count = '0;
      last_low = 1;
      last_high = 0;
      last_step = 0;
      mismatches = 0;
    endfunction

    function int unsigned fib(int unsigned k);
      int unsigned a;
      int unsigned b;
      int unsigned t;
      a = 0;
      b = 1;
      for (int unsigned i = 0; i < k && i < FIB_LEN; i++) begin
        t = a + b;
        a = b;
        b = t;
      end
      return a;
    endfunction

    function void set_entry_count(logic [IDX_W-1:0] v);
      entry_count = v;
    endfunction

    function void apply_word(logic op, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val,
                             logic [VAL_W-1:0] key);
      int unsigned    n;
      int unsigned    k;
      int unsigned    low;
      int unsigned    high;
      int unsigned    p;
      int unsigned    rd;
      int unsigned    probes;
      int signed      v;
      int signed      kv;
      logic           hit;
      logic [IDX_W-1:0] pos;
      search_result_t r;
      if (op == OP_LOAD) begin
        if (idx >= 1 && idx <= DEPTH) entries[idx-1] = val;
        return;
      end
      n = (entry_count > DEPTH) ? DEPTH : entry_count;
      k = 0;
      while (k + 1 < FIB_LEN && fib(k) < n + 1) k++;
      low = 1;
      high = n;
      probes = 0;
      pos = '0;
      hit = 1'b0;
      kv = $signed(key);
      while (low <= high && k >= 3 && !hit) begin
        p = low + fib(k - 1) - 1;
        rd = (p > n) ? n : p;
        v = $signed(entries[rd-1]);
        probes++;
        if (kv < v) begin
          high = p - 1;
          k -= 1;
        end else if (kv > v) begin
          low = p + 1;
          k -= 2;
        end else begin
          hit = 1'b1;
          pos = rd[IDX_W-1:0];
        end
      end
      last_low = low[IDX_W-1:0];
      last_high = high[IDX_W-1:0];
      last_step = k[3:0];
      r.found = hit;
      r.position = pos;
      r.probes = (probes > 15) ? CNT_MAX : probes[CNT_W-1:0];
      pending_results.push_back(r);
    endfunction

    task report_mismatch(string line);
      $display("mismatch: %s", line);
      mismatches++;
    endtask

    task check_result(logic found, logic [IDX_W-1:0] pos, logic [CNT_W-1:0] probes);
      search_result_t exp_r;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected word found=%0d position=%0d probes=%0d",
                                  found, pos, probes));
        return;
      end
      exp_r = pending_results.pop_front();
      if (found !== exp_r.found)
        report_mismatch($sformatf("found %0d, wanted %0d", found, exp_r.found));
      if (pos !== exp_r.position)
        report_mismatch($sformatf("position %0d, wanted %0d", pos, exp_r.position));
      if (probes !== exp_r.probes)
        report_mismatch($sformatf("probe count %0d, wanted %0d", probes, exp_r.probes));
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [IDX_W-1:0]      cfg_data;

  fib_search_checker sb;
  int unsigned       items_sent = 0;
  int unsigned       tx_idle_pct = 15;
  int unsigned       rx_idle_pct = 84;
  int unsigned       cycles = 0;
  int                table_vals [$];

  fibonacci_search_table_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tuser, m_axis_tdata[OUT_POS_LSB +: IDX_W],
                      m_axis_tdata[OUT_CNT_LSB +: CNT_W]);
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_word(logic op, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val,
                           logic [VAL_W-1:0] key);
    logic [IN_TDATA_W-1:0] word;
    word = '0;
    word[IN_IDX_LSB +: IDX_W] = idx;
    word[IN_VAL_LSB +: VAL_W] = val;
    word[IN_KEY_LSB +: VAL_W] = key;
    if (items_sent < ITEM_GOAL / 3) begin
      tx_idle_pct = 15;
      rx_idle_pct = 84;
    end else if (items_sent < 2 * ITEM_GOAL / 3) begin
      tx_idle_pct = 84;
      rx_idle_pct = 15;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= word;
    s_axis_tuser <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.apply_word(op, idx, val, key);
    items_sent++;
    @(negedge clk_i);
  endtask

  // hold the sender until every result is back, then let the block settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_count(logic [IDX_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk_i); while (!cfg_ready);
    sb.set_entry_count(v);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_table(int unsigned n);
    int  vals [$];
    bit  narrow;
    narrow = ($urandom_range(3) == 0);
    for (int unsigned i = 0; i < n; i++)
      vals.push_back(narrow ? int'($urandom_range(40)) - 20 : int'($urandom()));
    vals.sort();
    table_vals = vals;
    for (int unsigned i = 0; i < n; i++)
      send_word(OP_LOAD, IDX_W'(i + 1), vals[i], $urandom());
  endtask

  function automatic int pick_key();
    int unsigned r;
    r = $urandom_range(99);
    if (table_vals.size() == 0 || r < 15) return int'($urandom());
    if (r < 85) return table_vals[$urandom_range(table_vals.size() - 1)];
    return table_vals[$urandom_range(table_vals.size() - 1)] + ($urandom_range(1) ? 1 : -1);
  endfunction

  task automatic run_phase(int unsigned count, bit reload, int unsigned words);
    int unsigned r;
    int unsigned top;
    drain();
    write_count(IDX_W'(count));
    top = (count > DEPTH) ? DEPTH : count;
    if (reload) load_table(top);
    repeat (words) begin
      r = $urandom_range(99);
      if (r < 8) begin
        // loads outside the table are dropped by the block
        send_word(OP_LOAD, $urandom_range(1) ? IDX_W'(0) : IDX_W'($urandom_range(DEPTH + 1, 511)),
                  $urandom(), $urandom());
      end else if (r < 12 && top > 0) begin
        send_word(OP_LOAD, IDX_W'($urandom_range(1, top)), $urandom(), $urandom());
      end else begin
        send_word(OP_SEARCH, IDX_W'($urandom_range(511)), $urandom(), pick_key());
      end
    end
  endtask

  initial begin
    int unsigned phase_no;
    sb = new();
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty table, ignored loads and a load of the last entry
    write_count(0);
    send_word(OP_SEARCH, '0, '0, 32'h8000_0000);
    send_word(OP_SEARCH, 9'h1ff, 32'hffff_ffff, 32'h7fff_ffff);
    send_word(OP_LOAD, '0, 32'h1234_5678, '0);
    send_word(OP_LOAD, 9'h1ff, 32'h8765_4321, 32'hffff_ffff);
    send_word(OP_LOAD, IDX_W'(DEPTH), 32'hffff_ffff, '0);

    // three entries: the signed extremes and zero
    drain();
    write_count(3);
    table_vals = '{32'sh8000_0000, 0, 32'sh7fff_ffff};
    send_word(OP_LOAD, 9'd1, 32'h8000_0000, '0);
    send_word(OP_LOAD, 9'd2, 32'h0000_0000, '0);
    send_word(OP_LOAD, 9'd3, 32'h7fff_ffff, '0);
    send_word(OP_SEARCH, '0, '0, 32'h8000_0000);
    send_word(OP_SEARCH, '0, '0, 32'h0000_0000);
    send_word(OP_SEARCH, '0, '0, 32'h7fff_ffff);
    send_word(OP_SEARCH, '0, '0, 32'h0000_0001);
    send_word(OP_SEARCH, '0, '0, 32'h8000_0001);
    send_word(OP_SEARCH, '0, '0, 32'hffff_ffff);

    // single and two entry tables
    drain();
    write_count(1);
    send_word(OP_SEARCH, '0, '0, 32'h8000_0000);
    send_word(OP_SEARCH, '0, '0, 32'h0000_0005);
    drain();
    write_count(2);
    send_word(OP_SEARCH, '0, '0, 32'h0000_0000);
    send_word(OP_SEARCH, '0, '0, 32'h7fff_ffff);

    phase_no = 0;
    while (items_sent < ITEM_GOAL) begin
      if (phase_no == 4) run_phase(DEPTH, 1'b1, 40);
      else if (phase_no == 5) run_phase(511, 1'b0, 40);
      else if (phase_no % 9 == 7) run_phase(0, 1'b1, 10);
      else run_phase($urandom_range(1, 40), 1'b1, $urandom_range(15, 40));
      phase_no++;
    end

    drain();
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
